/* design/rbsd_pkg.sv */
package rbsd_pkg;

	localparam int WINDOW_LEN = 26;
	localparam int SYN_BITS   = 10;
	localparam int KIND_BITS  = 3;
	localparam int FILL_BITS  = 5;

	typedef logic [WINDOW_LEN-1:0] window_t;
	typedef logic [SYN_BITS-1:0]   syndrome_t;
	typedef logic [KIND_BITS-1:0]  kind_t;
	typedef logic [FILL_BITS-1:0]  fill_t;

	localparam kind_t KIND_A  = 3'd0;
	localparam kind_t KIND_B  = 3'd1;
	localparam kind_t KIND_C  = 3'd2;
	localparam kind_t KIND_CP = 3'd3;
	localparam kind_t KIND_D  = 3'd4;

	localparam syndrome_t OFFSET_A  = 10'b1111011000;
	localparam syndrome_t OFFSET_B  = 10'b1111010100;
	localparam syndrome_t OFFSET_C  = 10'b1001011100;
	localparam syndrome_t OFFSET_CP = 10'b1111001100;
	localparam syndrome_t OFFSET_D  = 10'b1001011000;

	localparam fill_t FILL_FULL = 5'd26;

	// Parity-check rows; row 0 goes with the oldest window bit.
	localparam syndrome_t CHECK_ROWS [WINDOW_LEN] = '{
		10'h200, 10'h100, 10'h080, 10'h040, 10'h020, 10'h010, 10'h008, 10'h004,
		10'h002, 10'h001, 10'h2DC, 10'h16E, 10'h0B7, 10'h287, 10'h39F, 10'h313,
		10'h355, 10'h376, 10'h1BB, 10'h201, 10'h3DC, 10'h1EE, 10'h0F7, 10'h2A7,
		10'h38F, 10'h31B
	};

	typedef struct packed {
		syndrome_t syndrome;
		logic      offset_found;
		kind_t     offset_kind;
	} result_t;

endpackage

/* design/rbsd_if.sv */
interface rbsd_sample_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface rbsd_result_if;
	logic                    valid;
	logic                    ready;
	rbsd_pkg::syndrome_t     syndrome;
	logic                    offset_found;
	rbsd_pkg::kind_t         offset_kind;

	modport source (output valid, output syndrome, output offset_found, output offset_kind,
		input ready);
	modport sink (input valid, input syndrome, input offset_found, input offset_kind,
		output ready);
endinterface

/* design/rbsd_syndrome.sv */
module rbsd_syndrome (
	input  rbsd_pkg::window_t window,
	output rbsd_pkg::result_t result
);

	rbsd_pkg::syndrome_t syn;

	// XOR tree over the check rows selected by window bits
	always_comb begin
		syn = '0;
		for (int r = 0; r < rbsd_pkg::WINDOW_LEN; r++) begin
			if (window[rbsd_pkg::WINDOW_LEN-1-r]) begin
				syn = syn ^ rbsd_pkg::CHECK_ROWS[r];
			end
		end
	end

	always_comb begin
		result.syndrome     = syn;
		result.offset_found = 1'b1;
		result.offset_kind  = rbsd_pkg::KIND_A;
		if (syn == rbsd_pkg::OFFSET_A) begin
			result.offset_kind = rbsd_pkg::KIND_A;
		end else if (syn == rbsd_pkg::OFFSET_B) begin
			result.offset_kind = rbsd_pkg::KIND_B;
		end else if (syn == rbsd_pkg::OFFSET_C) begin
			result.offset_kind = rbsd_pkg::KIND_C;
		end else if (syn == rbsd_pkg::OFFSET_CP) begin
			result.offset_kind = rbsd_pkg::KIND_CP;
		end else if (syn == rbsd_pkg::OFFSET_D) begin
			result.offset_kind = rbsd_pkg::KIND_D;
		end else begin
			result.offset_found = 1'b0;
		end
	end

endmodule

/* design/rds_block_sync_detector_top.sv */
// RDS block sync detector.
// samples (sink): one signed baseband sample per transfer, sliced to a line
//   bit (1 when greater than zero). Sample pairs are Manchester decoded,
//   invalid pairs dropped, then differentially decoded into a 26-bit window.
// results (source): once the window holds 26 bits, each new decoded bit gives
//   one transfer with the window syndrome and the matched offset word
//   (A, B, C, C', D), offset_found low and offset_kind A when none matches.
// Throughput: one sample per cycle while not stalled. The decoder state and
//   window update at the sample transfer; the syndrome XOR tree sits between
//   the window register and the output register.
// Pipeline: the sample transfer that completes a pair sets pend_s1; once the
//   stage advances, it moves into out_valid_q and results.valid rises.
// Reset: all pairing and decoding state clears, the window empties and no
//   result is pending; the first sample after reset is a first half.
// Stall: while a result waits in the output register, samples.ready drops
//   and the whole pipeline holds; nothing is lost or repeated.
module rds_block_sync_detector_top #(
	parameter int SAMPLE_BITS = 16
) (
	input logic              clk,
	input logic              arst_n,
	rbsd_sample_if.sink      samples,
	rbsd_result_if.source    results
);

	logic               pair_phase_q;
	logic               first_half_q;
	logic               prev_decoded_q;
	logic               seen_first_q;
	rbsd_pkg::window_t  window_q;
	rbsd_pkg::fill_t    fill_count_q;
	logic               pend_s1;

	logic               out_valid_q;
	rbsd_pkg::result_t  out_q;

	logic               advance;
	logic               take;
	logic               line_bit;
	logic               dbit;
	logic               pair_ok;
	rbsd_pkg::fill_t    fill_next;
	rbsd_pkg::result_t  syn_result;

	assign advance  = !out_valid_q || results.ready;
	assign take     = samples.valid && advance;
	assign line_bit = !samples.sample[SAMPLE_BITS-1] && (|samples.sample);
	assign pair_ok  = pair_phase_q && (first_half_q != line_bit);
	assign dbit     = seen_first_q ? (first_half_q ^ prev_decoded_q) : first_half_q;
	assign fill_next = (fill_count_q < rbsd_pkg::FILL_FULL) ? fill_count_q + 5'd1
		: fill_count_q;

	rbsd_syndrome u_syndrome (
		.window (window_q),
		.result (syn_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_phase_q   <= 1'b0;
			first_half_q   <= 1'b0;
			prev_decoded_q <= 1'b0;
			seen_first_q   <= 1'b0;
			window_q       <= '0;
			fill_count_q   <= '0;
			pend_s1        <= 1'b0;
		end else if (advance) begin
			pend_s1 <= 1'b0;
			if (take) begin
				pair_phase_q <= !pair_phase_q;
				if (!pair_phase_q) begin
					first_half_q <= line_bit;
				end
				if (pair_ok) begin
					prev_decoded_q <= first_half_q;
					seen_first_q   <= 1'b1;
					window_q       <= {window_q[rbsd_pkg::WINDOW_LEN-2:0], dbit};
					fill_count_q   <= fill_next;
					pend_s1        <= (fill_next == rbsd_pkg::FILL_FULL);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= pend_s1;
		end
	end

	// window_q still holds the flagged window when the stage advances
	always_ff @(posedge clk) begin
		if (advance && pend_s1) begin
			out_q <= syn_result;
		end
	end

	assign samples.ready        = advance;
	assign results.valid        = out_valid_q;
	assign results.syndrome     = out_q.syndrome;
	assign results.offset_found = out_q.offset_found;
	assign results.offset_kind  = out_q.offset_kind;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= rbsd_pkg::FILL_FULL)
		else $error("fill count past window length");

	a_pend_full: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> fill_count_q == rbsd_pkg::FILL_FULL)
		else $error("result pending before window full");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> out_valid_q)
		else $error("input stalled with no result waiting");

	a_kind_none: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.offset_found) |-> results.offset_kind == rbsd_pkg::KIND_A)
		else $error("offset kind set without a match");

	a_pending_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && advance) |=> out_valid_q)
		else $error("pending result dropped");
`endif

endmodule

/* test/rbsd_checker.sv */
`timescale 1ns / 1ps

package rbsd_tb_pkg;

	localparam rbsd_pkg::syndrome_t WORD_A  = 10'h3D8;
	localparam rbsd_pkg::syndrome_t WORD_B  = 10'h3D4;
	localparam rbsd_pkg::syndrome_t WORD_C  = 10'h25C;
	localparam rbsd_pkg::syndrome_t WORD_CP = 10'h3CC;
	localparam rbsd_pkg::syndrome_t WORD_D  = 10'h258;

	localparam rbsd_pkg::kind_t ALL_KINDS [5] = '{rbsd_pkg::KIND_A, rbsd_pkg::KIND_B,
		rbsd_pkg::KIND_C, rbsd_pkg::KIND_CP, rbsd_pkg::KIND_D};

	// row r pairs with window bit 25-r (oldest bit first)
	localparam rbsd_pkg::syndrome_t PARITY_ROWS [rbsd_pkg::WINDOW_LEN] = '{
		10'h200, 10'h100, 10'h080, 10'h040, 10'h020, 10'h010, 10'h008, 10'h004,
		10'h002, 10'h001, 10'h2DC, 10'h16E, 10'h0B7, 10'h287, 10'h39F, 10'h313,
		10'h355, 10'h376, 10'h1BB, 10'h201, 10'h3DC, 10'h1EE, 10'h0F7, 10'h2A7,
		10'h38F, 10'h31B
	};

	function automatic rbsd_pkg::syndrome_t window_syndrome(input rbsd_pkg::window_t w);
		rbsd_pkg::syndrome_t acc;
		acc = '0;
		for (int r = 0; r < rbsd_pkg::WINDOW_LEN; r++) begin
			if (w[rbsd_pkg::WINDOW_LEN-1-r]) acc ^= PARITY_ROWS[r];
		end
		return acc;
	endfunction

	function automatic rbsd_pkg::syndrome_t offset_word(input rbsd_pkg::kind_t k);
		case (k)
			rbsd_pkg::KIND_A:  return WORD_A;
			rbsd_pkg::KIND_B:  return WORD_B;
			rbsd_pkg::KIND_C:  return WORD_C;
			rbsd_pkg::KIND_CP: return WORD_CP;
			rbsd_pkg::KIND_D:  return WORD_D;
			default:           return WORD_A;
		endcase
	endfunction
endpackage

module rbsd_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  rbsd_pkg::syndrome_t           syndrome,
	input  logic                          offset_found,
	input  rbsd_pkg::kind_t               offset_kind,
	output int                            mismatches,
	output int                            due_count
);

	// decoder model state
	logic              half_held;
	logic              held_line;
	logic              last_mbit;
	logic              got_first;
	rbsd_pkg::window_t shift_reg;
	int                bits_in;

	rbsd_pkg::result_t syndromes_due [$];
	int                mismatch_count = 0;

	assign mismatches = mismatch_count;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic void append_due(input rbsd_pkg::result_t r);
		syndromes_due = {syndromes_due, r};
	endfunction

	// Advances the decoder by one line bit; returns 1 when a window result is due.
	function automatic bit decode_line(input logic line, output rbsd_pkg::result_t r);
		rbsd_pkg::syndrome_t syn;
		logic                dbit;
		r = '0;
		if (!half_held) begin
			held_line = line;
			half_held = 1'b1;
			return 1'b0;
		end
		half_held = 1'b0;
		if (held_line == line) return 1'b0;
		dbit = got_first ? (held_line ^ last_mbit) : held_line;
		last_mbit = held_line;
		got_first = 1'b1;
		shift_reg = {shift_reg[rbsd_pkg::WINDOW_LEN-2:0], dbit};
		if (bits_in < rbsd_pkg::WINDOW_LEN) bits_in++;
		if (bits_in < rbsd_pkg::WINDOW_LEN) return 1'b0;
		syn = rbsd_tb_pkg::window_syndrome(shift_reg);
		r.syndrome = syn;
		r.offset_found = 1'b0;
		r.offset_kind = rbsd_pkg::KIND_A;
		foreach (rbsd_tb_pkg::ALL_KINDS[i]) begin
			if (!r.offset_found && syn == rbsd_tb_pkg::offset_word(rbsd_tb_pkg::ALL_KINDS[i]))
			begin
				r.offset_found = 1'b1;
				r.offset_kind = rbsd_tb_pkg::ALL_KINDS[i];
			end
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		rbsd_pkg::result_t want;
		rbsd_pkg::result_t next_res;
		if (!arst_n) begin
			half_held = 1'b0;
			held_line = 1'b0;
			last_mbit = 1'b0;
			got_first = 1'b0;
			shift_reg = '0;
			bits_in = 0;
			syndromes_due.delete();
			due_count <= 0;
		end else begin
			// results leave the block through pend_s1 and the output register, so check first
			if (result_valid && result_ready) begin
				if (syndromes_due.size() == 0) begin
					report_mismatch("unexpected result, syndrome", int'(syndrome), 0);
				end else begin
					want = syndromes_due.pop_front();
					if (syndrome !== want.syndrome)
						report_mismatch("syndrome", int'(syndrome), int'(want.syndrome));
					if (offset_found !== want.offset_found)
						report_mismatch("offset_found", int'(offset_found),
							int'(want.offset_found));
					if (offset_kind !== want.offset_kind)
						report_mismatch("offset_kind", int'(offset_kind),
							int'(want.offset_kind));
				end
			end
			if (sample_valid && sample_ready) begin
				if (decode_line(sample > 0, next_res)) append_due(next_res);
			end
			due_count <= syndromes_due.size();
		end
	end
endmodule

/* test/tb_rds_block_sync_detector_top.sv */
`timescale 1ns / 1ps

module tb_rds_block_sync_detector_top;

	localparam int SAMPLE_BITS = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int SAMPLE_MAX = 2 ** (SAMPLE_BITS - 1) - 1;
	localparam int SAMPLE_MIN = -(2 ** (SAMPLE_BITS - 1));
	localparam int DATA_BITS = rbsd_pkg::WINDOW_LEN - rbsd_pkg::SYN_BITS;

	// line bits 10, 01, 11, 00, 01, 10, 10, 00, 01, 10, then a lone half
	localparam int OPENING [21] = '{SAMPLE_MAX, SAMPLE_MIN, 0, 1, 1, SAMPLE_MAX, -1, 0,
		SAMPLE_MIN, 2, 16384, -16384, 1, -1, 0, 0, -1, SAMPLE_MAX, 5, -5, SAMPLE_MAX};

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	logic clk;
	logic arst_n;
	int   src_idle_pct = 34;
	int   snk_idle_pct = 65;
	int   mismatch_total;
	int   results_due;
	int   quiet_cycles = 0;
	int   samples_sent = 0;

	// sender-side view of the line coding, used to build well-formed blocks
	bit half_held = 1'b0;
	bit held_line = 1'b0;
	bit last_mbit = 1'b0;
	bit got_first = 1'b0;

	rbsd_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples ();
	rbsd_result_if results ();

	rds_block_sync_detector_top #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results)
	);

	rbsd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (samples.valid),
		.sample_ready (samples.ready),
		.sample       (samples.sample),
		.result_valid (results.valid),
		.result_ready (results.ready),
		.syndrome     (results.syndrome),
		.offset_found (results.offset_found),
		.offset_kind  (results.offset_kind),
		.mismatches   (mismatch_total),
		.due_count    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		results.ready <= arst_n && ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples.valid && samples.ready) || (results.valid && results.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic sample_t pick_sample(input bit line);
		case ($urandom_range(7))
			0: return line ? sample_t'(SAMPLE_MAX) : sample_t'(SAMPLE_MIN);
			1: return line ? sample_t'(1) : sample_t'(0);
			default: return line ? sample_t'($urandom_range(SAMPLE_MAX, 1))
				: sample_t'(-int'($urandom_range(-SAMPLE_MIN, 0)));
		endcase
	endfunction

	task automatic drive_sample(input sample_t s);
		while ($urandom_range(99) < src_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid  <= 1'b1;
		samples.sample <= s;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		samples_sent++;
		if (!half_held) begin
			half_held = 1'b1;
			held_line = (s > 0);
		end else begin
			half_held = 1'b0;
			if (held_line != (s > 0)) begin
				last_mbit = held_line;
				got_first = 1'b1;
			end
		end
	endtask

	// one differentially coded bit as a Manchester pair
	task automatic send_dbit(input bit d);
		bit mbit;
		// realign with an invalid pair if a lone half is pending
		if (half_held) drive_sample(pick_sample(held_line));
		mbit = got_first ? (d ^ last_mbit) : d;
		drive_sample(pick_sample(mbit));
		drive_sample(pick_sample(!mbit));
	endtask

	// 16 random data bits plus a checkword that makes the window syndrome hit target
	task automatic send_block(input rbsd_pkg::syndrome_t target);
		rbsd_pkg::window_t bits;
		logic [31:0]       rnd;
		rnd = $urandom;
		bits = '0;
		bits[DATA_BITS-1:0] = rnd[DATA_BITS-1:0];
		bits[rbsd_pkg::WINDOW_LEN-1 -: rbsd_pkg::SYN_BITS] =
			rbsd_tb_pkg::window_syndrome(bits) ^ target;
		for (int i = rbsd_pkg::WINDOW_LEN - 1; i >= 0; i--) send_dbit(bits[i]);
	endtask

	task automatic run_traffic(input int count);
		int start;
		start = samples_sent;
		while (samples_sent - start < count) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4: send_block(rbsd_tb_pkg::offset_word(
					rbsd_tb_pkg::ALL_KINDS[$urandom_range(4)]));
				5: send_block(rbsd_pkg::syndrome_t'($urandom));
				6: repeat ($urandom_range(5, 1)) drive_sample(sample_t'($urandom));
				7: repeat ($urandom_range(12, 1)) send_dbit(1'($urandom_range(1)));
				default: begin
					send_block(rbsd_tb_pkg::offset_word(rbsd_pkg::KIND_A));
					send_block(rbsd_tb_pkg::offset_word(rbsd_pkg::KIND_B));
					send_block(rbsd_tb_pkg::offset_word($urandom_range(1) ? rbsd_pkg::KIND_C
						: rbsd_pkg::KIND_CP));
					send_block(rbsd_tb_pkg::offset_word(rbsd_pkg::KIND_D));
				end
			endcase
		end
	endtask

	task automatic wait_results_done();
		samples.valid <= 1'b0;
		// let the last sample transfer reach the due count before it is polled
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.sample = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (OPENING[i]) drive_sample(sample_t'(OPENING[i]));
		run_traffic(220);
		wait_results_done();

		src_idle_pct = 65;
		snk_idle_pct = 34;
		run_traffic(230);
		wait_results_done();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		run_traffic(230);
		wait_results_done();

		repeat (6) @(posedge clk);
		if (mismatch_total == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
